>>> rtl/dfu_pkg.sv
// ----------------------------------------------------------------------------
// DFU control package
// Types, codes and helper functions shared by the DFU control state machine.
// ----------------------------------------------------------------------------
package dfu_pkg;

   // Endpoint-zero maximum packet size in bytes.
   localparam int EP0_BYTES = 64;

   // Depth of the queue between the classifier and the result sequencer.
   // Must be a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request codes.
   localparam logic [7:0] REQ_DNLOAD    = 8'd1;
   localparam logic [7:0] REQ_UPLOAD    = 8'd2;
   localparam logic [7:0] REQ_GETSTATUS = 8'd3;
   localparam logic [7:0] REQ_CLRSTATUS = 8'd4;
   localparam logic [7:0] REQ_GETSTATE  = 8'd5;
   localparam logic [7:0] REQ_ABORT     = 8'd6;

   // Input action codes.
   localparam logic ACT_SETUP = 1'b0;
   localparam logic ACT_OUT   = 1'b1;

   // Status codes.
   localparam logic [3:0] STATUS_OK      = 4'd0;
   localparam logic [3:0] STATUS_STALLED = 4'd15;

   // Reported state codes.
   localparam logic [3:0] CODE_IDLE     = 4'd2;
   localparam logic [3:0] CODE_DNBUSY   = 4'd4;
   localparam logic [3:0] CODE_DNIDLE   = 4'd5;
   localparam logic [3:0] CODE_MSYNC    = 4'd6;
   localparam logic [3:0] CODE_MANIFEST = 4'd7;
   localparam logic [3:0] CODE_ERROR    = 4'd10;

   localparam logic [2:0] STATUS_MAX_LEN = 3'd6;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DNBUSY   = 6'b000010,
      ST_DNIDLE   = 6'b000100,
      ST_MSYNC    = 6'b001000,
      ST_MANIFEST = 6'b010000,
      ST_ERROR    = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      KIND_OUT      = 3'd0,
      KIND_IN       = 3'd1,
      KIND_STALL    = 3'd2,
      KIND_START    = 3'd3,
      KIND_PACKET   = 3'd4,
      KIND_DONE     = 3'd5,
      KIND_MANIFEST = 3'd6
   } kind_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  request;
      logic [15:0] block_number;
      logic [15:0] setup_length;
      logic [6:0]  packet_length;
      logic        reject;
      logic [3:0]  reject_status;
      logic [15:0] poll_wait;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  in_length;
      logic [3:0]  status_code;
      logic [15:0] poll_timeout;
      logic [3:0]  state_code;
      logic [15:0] block_id;
      logic [15:0] block_offset;
      logic [15:0] data_length;
   } result_type;

   // All results caused by one item, in delivery order from index zero.
   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] res;
   } bundle_type;

   function automatic logic [3:0] state_code(input state_type st);
      logic [3:0] code;
      case (st)
         ST_IDLE:     code = CODE_IDLE;
         ST_DNBUSY:   code = CODE_DNBUSY;
         ST_DNIDLE:   code = CODE_DNIDLE;
         ST_MSYNC:    code = CODE_MSYNC;
         ST_MANIFEST: code = CODE_MANIFEST;
         ST_ERROR:    code = CODE_ERROR;
         default:     code = CODE_ERROR;
      endcase
      return code;
   endfunction

   function automatic result_type make_res(input kind_type k, input logic [2:0] len,
                                           input logic [3:0] st, input logic [15:0] poll,
                                           input logic [3:0] sc, input logic [15:0] blk,
                                           input logic [15:0] off, input logic [15:0] dlen);
      result_type r;
      r.kind         = k;
      r.in_length    = len;
      r.status_code  = st;
      r.poll_timeout = poll;
      r.state_code   = sc;
      r.block_id     = blk;
      r.block_offset = off;
      r.data_length  = dlen;
      return r;
   endfunction

endpackage

>>> rtl/dfu_front.sv
// ----------------------------------------------------------------------------
// DFU classifier
// Accepts setup and OUT-completion transactions, updates the protocol state
// and builds the bundle of results that each transaction causes.
// ----------------------------------------------------------------------------
module dfu_front import dfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   input  logic       q_full,
   output logic       push,
   output bundle_type push_bundle
);

   state_type   state_ff, state_in;
   logic [3:0]  status_ff, status_in;
   logic [15:0] poll_ff, poll_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  lreq_ff, lreq_in;
   logic [15:0] lblk_ff, lblk_in;
   logic [15:0] llen_ff, llen_in;

   logic        accept;
   logic [16:0] sum;
   logic [2:0]  slen_clip;
   bundle_type  bund;
   logic [1:0]  n;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign sum      = {1'b0, offset_ff} + 17'(EP0_BYTES);
   assign slen_clip = (in_item.setup_length > 16'(STATUS_MAX_LEN)) ? STATUS_MAX_LEN
                                                                   : in_item.setup_length[2:0];

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      poll_in   = poll_ff;
      offset_in = offset_ff;
      lreq_in   = lreq_ff;
      lblk_in   = lblk_ff;
      llen_in   = llen_ff;
      bund      = '0;
      n         = 2'd0;
      if (in_item.action == ACT_SETUP) begin
         lreq_in = in_item.request;
         lblk_in = in_item.block_number;
         llen_in = in_item.setup_length;
         case (in_item.request)
            REQ_DNLOAD: begin
               if (state_ff inside {ST_IDLE, ST_DNIDLE}) begin
                  if (in_item.setup_length == 16'd0) begin
                     state_in = ST_MSYNC;
                     bund.res[0] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
                     bund.res[1] = make_res(KIND_IN, '0, '0, '0, '0, '0, '0, '0);
                  end else begin
                     offset_in = '0;
                     bund.res[0] = make_res(KIND_START, '0, '0, '0, '0,
                                            in_item.block_number, '0,
                                            in_item.setup_length);
                     if (in_item.reject) begin
                        status_in = in_item.reject_status;
                        state_in  = ST_ERROR;
                        bund.res[1] = make_res(KIND_STALL, '0, '0, '0, '0, '0, '0, '0);
                     end else begin
                        state_in = ST_DNBUSY;
                        bund.res[1] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
                     end
                  end
                  n = 2'd2;
               end else begin
                  status_in = STATUS_STALLED;
                  state_in  = ST_ERROR;
                  bund.res[0] = make_res(KIND_STALL, '0, '0, '0, '0, '0, '0, '0);
                  n = 2'd1;
               end
            end
            REQ_UPLOAD: begin
               status_in = STATUS_STALLED;
               state_in  = ST_ERROR;
               bund.res[0] = make_res(KIND_STALL, '0, '0, '0, '0, '0, '0, '0);
               n = 2'd1;
            end
            REQ_GETSTATUS: begin
               // A status poll in manifest sync moves on to manifest first.
               if (state_ff == ST_MSYNC) begin
                  state_in = ST_MANIFEST;
                  bund.res[0] = make_res(KIND_MANIFEST, '0, '0, '0, '0, '0, '0, '0);
                  bund.res[1] = make_res(KIND_IN, slen_clip, status_ff, poll_ff,
                                         CODE_MANIFEST, '0, '0, '0);
                  bund.res[2] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
                  n = 2'd3;
               end else begin
                  bund.res[0] = make_res(KIND_IN, slen_clip, status_ff, poll_ff,
                                         state_code(state_ff), '0, '0, '0);
                  bund.res[1] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
                  n = 2'd2;
               end
            end
            REQ_CLRSTATUS, REQ_ABORT: begin
               state_in  = ST_IDLE;
               status_in = STATUS_OK;
               poll_in   = '0;
               bund.res[0] = make_res(KIND_IN, '0, '0, '0, '0, '0, '0, '0);
               bund.res[1] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
               n = 2'd2;
            end
            REQ_GETSTATE: begin
               bund.res[0] = make_res(KIND_IN, 3'd1, '0, '0, state_code(state_ff),
                                      '0, '0, '0);
               bund.res[1] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
               n = 2'd2;
            end
            default: begin
               bund.res[0] = make_res(KIND_STALL, '0, '0, '0, '0, '0, '0, '0);
               n = 2'd1;
            end
         endcase
      end else if (lreq_ff == REQ_DNLOAD) begin
         // OUT data of a download: an empty packet gives no packet event.
         if (in_item.packet_length != 7'd0) begin
            bund.res[n] = make_res(KIND_PACKET, '0, '0, '0, '0, lblk_ff, offset_ff,
                                   {9'd0, in_item.packet_length});
            n = n + 2'd1;
         end
         offset_in = sum[16] ? 16'hFFFF : sum[15:0];
         if (sum >= {1'b0, llen_ff}) begin
            poll_in = in_item.poll_wait;
            bund.res[n] = make_res(KIND_DONE, '0, '0, '0, '0, lblk_ff, '0, llen_ff);
            n = n + 2'd1;
            if (in_item.poll_wait == 16'd0 && status_ff == STATUS_OK) begin
               state_in = ST_DNIDLE;
               bund.res[n] = make_res(KIND_IN, '0, '0, '0, '0, '0, '0, '0);
               n = n + 2'd1;
            end
         end else begin
            bund.res[n] = make_res(KIND_OUT, '0, '0, '0, '0, '0, '0, '0);
            n = n + 2'd1;
         end
      end
      bund.count = n;
   end

   assign push        = accept && (n != 2'd0);
   assign push_bundle = bund;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_OK;
         poll_ff   <= '0;
         offset_ff <= '0;
         lreq_ff   <= '0;
         lblk_ff   <= '0;
         llen_ff   <= '0;
      end else if (accept) begin
         state_ff  <= state_in;
         status_ff <= status_in;
         poll_ff   <= poll_in;
         offset_ff <= offset_in;
         lreq_ff   <= lreq_in;
         lblk_ff   <= lblk_in;
         llen_ff   <= llen_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("protocol state is not one-hot");

   a_setup_latch: assert property (@(posedge clock) disable iff (reset)
      (accept && in_item.action == ACT_SETUP) |=> lreq_ff == $past(in_item.request))
      else $error("setup request not latched");

endmodule

>>> rtl/dfu_queue.sv
// ----------------------------------------------------------------------------
// DFU result queue
// Short queue of result bundles between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module dfu_queue import dfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output logic       q_valid,
   output bundle_type q_bundle
);

   bundle_type mem [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_bundle = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && q_valid;

   // Pointers wrap naturally since the depth is a power of two.
   assign wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == QCNT_W'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

>>> rtl/dfu_back.sv
// ----------------------------------------------------------------------------
// DFU result sequencer
// Takes one bundle at a time from the queue and delivers its results one per
// transaction, marking the last one.
// ----------------------------------------------------------------------------
module dfu_back import dfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  bundle_type q_bundle,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res,
   output logic       out_last
);

   logic       busy_ff, busy_in;
   bundle_type bund_ff, bund_in;
   logic [1:0] idx_ff, idx_in;
   logic       xfer, done;

   assign out_valid = busy_ff;
   assign out_res   = bund_ff.res[idx_ff];
   assign out_last  = (idx_ff == bund_ff.count - 2'd1);
   assign xfer      = busy_ff && out_ready;
   assign done      = xfer && out_last;
   assign pop       = q_valid && (!busy_ff || done);

   always_comb begin
      busy_in = busy_ff;
      bund_in = bund_ff;
      idx_in  = idx_ff;
      if (pop) begin
         busy_in = 1'b1;
         bund_in = q_bundle;
         idx_in  = 2'd0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (xfer) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      bund_ff <= bund_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bund_ff.count != 2'd0) && (idx_ff < bund_ff.count))
      else $error("result index outside its bundle");

   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !out_ready) |=> $stable(idx_ff) && busy_ff)
      else $error("result index moved while stalled");

endmodule

>>> rtl/dfu_control_state_machine_top.sv
// ----------------------------------------------------------------------------
// DFU control state machine
// Device-side DFU control protocol on endpoint zero: classifies setup and OUT
// completions, tracks protocol state and emits endpoint and back-end actions.
//
//   Channel | Direction | Ports                    | Contents
//   req     | in        | tvalid tready tuser tdata | setup or OUT completion
//   rsp     | out       | tvalid tready tuser tdata | endpoint / back-end action
//                         tlast                     | last result of a transaction
//
// A request transaction is taken in the cycle it is offered while the bundle
// queue has room; its state update completes in that cycle.
// Each request causes zero to three results, delivered one per cycle by the
// sequencer while rsp_tready is high, through the single result port. The
// first result passes through the bundle queue and then the sequencer's bundle
// register before it is offered.
// Reset (synchronous) returns to dfu idle with status ok and an empty queue.
// A stalled result side fills the queue and then holds req_tready low.
// ----------------------------------------------------------------------------
module dfu_control_state_machine_top import dfu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] action
   // [7:0] request, [23:8] block_number, [39:24] setup_length,
   // [46:40] packet_length, [47] reject, [51:48] reject_status,
   // [67:52] poll_wait, [71:68] zero
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   // [2:0] in_length, [6:3] status_code, [22:7] poll_timeout,
   // [26:23] state_code, [42:27] block_id, [58:43] block_offset,
   // [74:59] data_length, [79:75] zero
   output logic [79:0] rsp_tdata,
   output logic        rsp_tlast
);

   item_type   item;
   logic       q_full, push, pop, q_valid;
   bundle_type push_bundle, q_bundle;
   result_type res;

   assign item.action        = req_tuser;
   assign item.request       = req_tdata[7:0];
   assign item.block_number  = req_tdata[23:8];
   assign item.setup_length  = req_tdata[39:24];
   assign item.packet_length = req_tdata[46:40];
   assign item.reject        = req_tdata[47];
   assign item.reject_status = req_tdata[51:48];
   assign item.poll_wait     = req_tdata[67:52];

   dfu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (item),
      .q_full      (q_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   dfu_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (q_full),
      .pop         (pop),
      .q_valid     (q_valid),
      .q_bundle    (q_bundle)
   );

   dfu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_bundle  (q_bundle),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = res.kind;
   assign rsp_tdata = {5'd0, res.data_length, res.block_offset, res.block_id,
                       res.state_code, res.poll_timeout, res.status_code,
                       res.in_length};

endmodule
